// File: rtl/mandelbrot_escape_pixel_assert.svh
// Assertion macros for the escape-time pixel unit.
// Used by the port checker; needs clk and rst in the scope of the user.
`ifndef MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define MEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MEP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mep_pkg.sv
// Shared types and constants for the escape-time pixel unit.
// No dependencies; imported by the multiplier, the divider and the top level.
`timescale 1ns / 1ps

package mep_pkg;

  // Default fixed-point format.
  localparam int FRAC_BITS_DEF   = 26;
  localparam int COORD_WIDTH_DEF = 32;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_PIXEL_STEP   = 3'd2;
  localparam logic [2:0] REG_MAX_ITER     = 3'd3;
  localparam logic [2:0] REG_ESCAPE_R2    = 3'd4;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd5;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [31:0] RST_ORIGIN_X     = 32'hF600_0000;
  localparam logic [31:0] RST_ORIGIN_Y     = 32'h0500_0000;
  localparam logic [30:0] RST_PIXEL_STEP   = 31'd335544;
  localparam logic [10:0] RST_MAX_ITER     = 11'd256;
  localparam logic [30:0] RST_ESCAPE_R2    = 31'd268435456;
  localparam logic [12:0] RST_FRAME_WIDTH  = 13'd800;
  localparam logic [12:0] RST_FRAME_HEIGHT = 13'd600;

  // Colouring constants.
  localparam logic [31:0] RED_BIAS   = 32'd69;
  localparam logic [10:0] RED_MOD    = 11'd68;
  localparam logic [7:0]  RED_BASE   = 8'd81;
  localparam logic [31:0] BLUE_BIAS  = 32'd27;
  localparam logic [10:0] BLUE_MOD   = 11'd67;
  localparam logic [7:0]  BLUE_BASE  = 8'd100;

  // Reciprocals of the colour moduli, scaled by 2^RECIP_SHIFT and rounded up.
  // They give exact quotients for magnitudes up to 2^31.
  localparam int          RECIP_SHIFT = 37;
  localparam logic [31:0] RED_RECIP   = 32'd2021161081;
  localparam logic [31:0] BLUE_RECIP  = 32'd2051327664;

  // Modes of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_INT,
    MUL_FIX,
    MUL_WRAP
  } mul_mode_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADDR,
    ST_CR,
    ST_CI,
    ST_X2,
    ST_Y2,
    ST_CHK,
    ST_G,
    ST_CC,
    ST_B,
    ST_DIV1,
    ST_INT,
    ST_GR,
    ST_RN,
    ST_DIV2,
    ST_REM1S,
    ST_REM1,
    ST_REM2S,
    ST_REM2,
    ST_OUT
  } state_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: rtl/mep_mul.sv
// Shared multiplier: exact magnitude product, optional fraction shift,
// saturation to the coordinate range, and a wrapped low word. Uses mep_pkg.
`timescale 1ns / 1ps

module mep_mul import mep_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int MW          = 32
) (
  input  logic signed [MW-1:0]          a,
  input  logic signed [MW-1:0]          b,
  input  mul_mode_t                     mode,
  output logic signed [COORD_WIDTH-1:0] fix,
  output logic [31:0]                   lo,
  output logic [31:0]                   hi
);

  localparam int PW = 2 * MW;
  localparam logic [PW-1:0] LIM = (PW'(1) << (COORD_WIDTH - 1)) - PW'(1);

  logic          neg;
  logic [MW-1:0] ua;
  logic [MW-1:0] ub;
  logic [PW-1:0] prod;
  logic [PW-1:0] sprod;
  logic [PW-1:0] lim;
  logic [COORD_WIDTH-1:0] mag;

  // Multiply magnitudes so that truncation goes toward zero.
  always_comb begin
    neg   = a[MW-1] ^ b[MW-1];
    ua    = a[MW-1] ? (~a + MW'(1)) : a;
    ub    = b[MW-1] ? (~b + MW'(1)) : b;
    prod  = PW'(ua) * PW'(ub);
    sprod = (mode == MUL_FIX) ? (prod >> FRAC_BITS) : prod;
    lim   = LIM + PW'(neg);
    mag   = sprod[COORD_WIDTH-1:0];
  end

  // Saturate to the signed coordinate range, then restore the sign.
  always_comb begin
    if (sprod > lim) begin
      fix = neg ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      fix = neg ? signed'(~mag + COORD_WIDTH'(1)) : signed'(mag);
    end
    lo = neg ? (~prod[31:0] + 32'd1) : prod[31:0];
    // Upper word of the magnitude product, used for reciprocal division.
    hi = prod[63:32];
  end

endmodule

// File: rtl/mep_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// The quotient truncates toward zero. Uses mep_pkg.
`timescale 1ns / 1ps

module mep_div import mep_pkg::*; #(
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic [10:0]          divisor,
  output div_status_t          status,
  output logic signed [DW-1:0] quot
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic          sgn;
  logic [DW-1:0] mag;
  logic [10:0]   dvs;
  logic [10:0]   part;
  logic [11:0]   trial;
  logic          fits;

  // One restoring step.
  always_comb begin
    trial = {part, mag[DW-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // Control of the step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift register of dividend and quotient, plus partial remainder.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      sgn  <= dividend[DW-1];
      mag  <= dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
      dvs  <= divisor;
      part <= '0;
    end else if (busy) begin
      mag  <= {mag[DW-2:0], fits};
      part <= fits ? 11'(trial - {1'b0, dvs}) : trial[10:0];
    end
  end

  always_comb begin
    status.busy = busy;
    status.done = done;
    quot = sgn ? signed'(~mag + DW'(1)) : signed'(mag);
  end

endmodule

// File: rtl/mandelbrot_escape_pixel.sv
// Escape-time pixel unit: one pixel per request, with address and colour.
// The address and c are formed in ST_ADDR, ST_CR and ST_CI, each iteration in
// ST_X2, ST_Y2 and ST_CHK, and the colour of an escaped pixel from ST_G to ST_REM2;
// one pixel in flight at a time, as the multiplier and the divider are shared.
// Reset (rst, synchronous) loads the register defaults and empties the unit.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel import mep_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] col,
  input  logic [11:0] row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] pixel_address,
  output logic [7:0]  red,
  output logic        green,
  output logic [7:0]  blue,
  output logic        escaped,
  output logic [10:0] iter_count
);

  localparam int W  = COORD_WIDTH;
  localparam int MW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam logic signed [64:0] CMAX = (65'sd1 <<< (W - 1)) - 65'sd1;
  localparam logic signed [64:0] CMIN = -CMAX - 65'sd1;
  localparam logic signed [64:0] RND  = (65'sd1 <<< FRAC_BITS) - 65'sd1;

  // Clamp a wide signed value to the coordinate range.
  function automatic logic signed [W-1:0] clampw(input logic signed [64:0] v);
    if (v > CMAX) begin
      return W'(CMAX);
    end else if (v < CMIN) begin
      return W'(CMIN);
    end
    return W'(v);
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] x,
                                               input logic signed [W-1:0] y);
    return clampw(65'(x) + 65'(y));
  endfunction

  // Integer part toward zero, saturated to 32 bits.
  function automatic logic [31:0] intpart(input logic signed [W-1:0] q);
    logic signed [64:0] t;
    t = 65'(q) + (q[W-1] ? RND : 65'sd0);
    t = t >>> FRAC_BITS;
    if (t > 65'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (t < -65'sd2147483648) begin
      return 32'h8000_0000;
    end
    return t[31:0];
  endfunction

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic signed [W-1:0] origin_x;
  logic signed [W-1:0] origin_y;
  logic [30:0]         pixel_step;
  logic [10:0]         max_iter;
  logic [30:0]         escape_r2;
  logic [12:0]         frame_width;
  logic [12:0]         frame_height;

  // Working registers.
  logic [11:0]         col_q;
  logic [11:0]         row_q;
  logic signed [W-1:0] cr;
  logic signed [W-1:0] ci;
  logic signed [W-1:0] zr;
  logic signed [W-1:0] zi;
  logic signed [W-1:0] x2;
  logic signed [W-1:0] y2;
  logic signed [W-1:0] gfix;
  logic signed [W-1:0] ccfix;
  logic signed [W-1:0] bfix;
  logic signed [W-1:0] q1;
  logic [10:0]         iter;
  logic [10:0]         n;
  logic [31:0]         gg;
  logic [31:0]         rr;
  logic [31:0]         bb;
  logic [31:0]         rs;
  logic [31:0]         rn;
  logic [31:0]         bs;
  logic [26:0]         rq;

  // Shared units.
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  mul_mode_t            mul_mode;
  logic signed [W-1:0]  mul_fix;
  logic [31:0]          mul_lo;
  logic [31:0]          mul_hi;
  logic                 div_start;
  logic signed [MW-1:0] div_a;
  logic [10:0]          div_d;
  div_status_t          div_st;
  logic signed [MW-1:0] div_q;

  logic [10:0]         n1;
  logic [11:0]         iter_inc;
  logic signed [W-1:0] r2;
  logic                esc_hit;
  logic signed [W-1:0] ci_new;
  logic [31:0]         rs_mag;
  logic [31:0]         bs_mag;
  logic [6:0]          red_rem;
  logic [6:0]          blue_rem;

  mep_mul #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH),
    .MW          (MW)
  ) u_mul (
    .a    (mul_a),
    .b    (mul_b),
    .mode (mul_mode),
    .fix  (mul_fix),
    .lo   (mul_lo),
    .hi   (mul_hi)
  );

  mep_div #(
    .DW (MW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .status   (div_st),
    .quot     (div_q)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= clampw(65'(signed'(RST_ORIGIN_X)));
      origin_y     <= clampw(65'(signed'(RST_ORIGIN_Y)));
      pixel_step   <= RST_PIXEL_STEP;
      max_iter     <= RST_MAX_ITER;
      escape_r2    <= RST_ESCAPE_R2;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN_X:     origin_x     <= clampw(65'(signed'(cfg_data)));
        REG_ORIGIN_Y:     origin_y     <= clampw(65'(signed'(cfg_data)));
        REG_PIXEL_STEP:   pixel_step   <= cfg_data[30:0];
        REG_MAX_ITER:     max_iter     <= cfg_data[10:0];
        REG_ESCAPE_R2:    escape_r2    <= cfg_data[30:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[12:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Escape test and orbit helpers.
  always_comb begin
    n1       = n + 11'd1;
    iter_inc = {1'b0, iter} + 12'd1;
    r2       = sadd(x2, y2);
    esc_hit  = 65'(r2) >= signed'({34'd0, escape_r2});
    ci_new   = sadd(origin_y, mul_fix);
  end

  // Colour remainders: magnitude minus quotient times modulus.
  always_comb begin
    rs_mag   = rs[31] ? (~rs + 32'd1) : rs;
    bs_mag   = bs[31] ? (~bs + 32'd1) : bs;
    red_rem  = 7'(rs_mag - 32'(rq) * 32'(RED_MOD));
    blue_rem = 7'(bs_mag - 32'(rq) * 32'(BLUE_MOD));
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ADDR;
      ST_ADDR:  state_next = ST_CR;
      ST_CR:    state_next = ST_CI;
      ST_CI:    state_next = (max_iter == 11'd0) ? ST_OUT : ST_X2;
      ST_X2:    state_next = ST_Y2;
      ST_Y2:    state_next = ST_CHK;
      ST_CHK: begin
        if (esc_hit) begin
          state_next = ST_G;
        end else if (iter_inc == {1'b0, max_iter}) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_X2;
        end
      end
      ST_G:     state_next = ST_CC;
      ST_CC:    state_next = ST_B;
      ST_B:     state_next = ST_DIV1;
      ST_DIV1:  if (div_st.done) state_next = ST_INT;
      ST_INT:   state_next = ST_GR;
      ST_GR:    state_next = ST_RN;
      ST_RN:    state_next = ST_DIV2;
      ST_DIV2:  if (div_st.done) state_next = ST_REM1S;
      ST_REM1S: state_next = ST_REM1;
      ST_REM1:  state_next = ST_REM2S;
      ST_REM2S: state_next = ST_REM2;
      ST_REM2:  state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Unit controls and handshake outputs.
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    mul_a     = '0;
    mul_b     = '0;
    mul_mode  = MUL_INT;
    div_start = 1'b0;
    div_a     = MW'(ci);
    div_d     = n1;
    case (state)
      ST_ADDR: begin
        mul_a    = MW'(24'(frame_height) - 24'd1 - 24'(row_q));
        mul_b    = MW'(frame_width);
        mul_mode = MUL_WRAP;
      end
      ST_CR: begin
        mul_a = MW'(col_q);
        mul_b = MW'(pixel_step);
      end
      ST_CI: begin
        mul_a = MW'(row_q);
        mul_b = MW'(pixel_step);
      end
      ST_X2: begin
        mul_a    = MW'(zr);
        mul_b    = MW'(zr);
        mul_mode = MUL_FIX;
      end
      ST_Y2: begin
        mul_a    = MW'(zi);
        mul_b    = MW'(zi);
        mul_mode = MUL_FIX;
      end
      ST_CHK: begin
        mul_a    = MW'(zr);
        mul_b    = MW'(zi);
        mul_mode = MUL_FIX;
      end
      ST_G: begin
        mul_a     = MW'(cr);
        mul_b     = MW'(n1);
        div_start = 1'b1;
      end
      ST_CC: begin
        mul_a    = MW'(cr);
        mul_b    = MW'(ci);
        mul_mode = MUL_FIX;
      end
      ST_B: begin
        mul_a = MW'(ccfix);
        mul_b = MW'(n);
      end
      ST_GR: begin
        mul_a     = MW'(signed'(gg));
        mul_b     = MW'(signed'(rr));
        mul_mode  = MUL_WRAP;
        div_start = 1'b1;
        div_a     = MW'(signed'(bb));
      end
      ST_RN: begin
        mul_a    = MW'(signed'(rr));
        mul_b    = MW'(n);
        mul_mode = MUL_WRAP;
      end
      ST_REM1S: begin
        mul_a = MW'(signed'(rs));
        mul_b = MW'(RED_RECIP);
      end
      ST_REM2S: begin
        mul_a = MW'(signed'(bs));
        mul_b = MW'(BLUE_RECIP);
      end
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers, loaded by state.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        col_q <= col;
        row_q <= row;
      end
      ST_ADDR: pixel_address <= 24'(col_q) + mul_lo[23:0];
      ST_CR:   cr <= sadd(origin_x, mul_fix);
      ST_CI: begin
        ci         <= ci_new;
        zr         <= cr;
        zi         <= ci_new;
        iter       <= '0;
        escaped    <= 1'b0;
        iter_count <= max_iter;
        red        <= '0;
        blue       <= '0;
        n          <= max_iter;
      end
      ST_X2: x2 <= mul_fix;
      ST_Y2: y2 <= mul_fix;
      ST_CHK: begin
        if (esc_hit) begin
          n          <= iter;
          iter_count <= iter;
          escaped    <= 1'b1;
        end else begin
          zr   <= sadd(sadd(x2, -y2), cr);
          zi   <= sadd(sadd(mul_fix, mul_fix), ci);
          iter <= iter_inc[10:0];
        end
      end
      ST_G:    gfix  <= mul_fix;
      ST_CC:   ccfix <= mul_fix;
      ST_B:    bfix  <= mul_fix;
      ST_DIV1: q1    <= div_q[W-1:0];
      ST_INT: begin
        rr <= intpart(sadd(gfix, q1));
        gg <= intpart(gfix);
        bb <= intpart(bfix);
      end
      ST_GR:   rs <= 32'(n) + mul_lo + RED_BIAS;
      ST_RN:   rn <= mul_lo;
      ST_DIV2: bs <= rn + div_q[31:0] + BLUE_BIAS;
      // Quotient of the magnitude by the modulus, from the scaled reciprocal.
      ST_REM1S: rq <= 27'(mul_hi >> (RECIP_SHIFT - 32));
      ST_REM1:  red <= rs[31] ? (RED_BASE - 8'(red_rem)) : (RED_BASE + 8'(red_rem));
      ST_REM2S: rq <= 27'(mul_hi >> (RECIP_SHIFT - 32));
      ST_REM2:  blue <= bs[31] ? (BLUE_BASE - 8'(blue_rem)) : (BLUE_BASE + 8'(blue_rem));
      default: ;
    endcase
  end

  assign green = 1'b0;

endmodule

// File: rtl/mep_checker.sv
// Port checker for the escape-time pixel unit, bound to the top level.
// Depends on mandelbrot_escape_pixel_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "mandelbrot_escape_pixel_assert.svh"

module mep_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_write,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [11:0] col,
  input logic [11:0] row,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] pixel_address,
  input logic [7:0]  red,
  input logic        green,
  input logic [7:0]  blue,
  input logic        escaped,
  input logic [10:0] iter_count
);

  // A waiting result beat keeps its payload.
  `MEP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pixel_address) && $stable(red) && $stable(blue) && $stable(iter_count), "result beat changed while stalled")

  // One pixel in flight: no new beat is taken while a result waits.
  `MEP_ASSERT(a_one_inflight, out_valid |-> !in_ready, "input taken while result pending")

  // Pixels inside the set are black.
  `MEP_ASSERT(a_black_inside, out_valid && !escaped |-> red == 8'd0 && blue == 8'd0, "inside pixel not black")

  // Escaped colours stay in the band set by the remainders.
  `MEP_ASSERT(a_color_band, out_valid && escaped |-> red >= 8'd14 && red <= 8'd148 && blue >= 8'd34 && blue <= 8'd166, "escaped colour out of band")

  // Green is never lit.
  `MEP_ASSERT_ALWAYS(a_green_off, !green, "green driven high")

endmodule

bind mandelbrot_escape_pixel mep_port_checker u_mep_checker (.*);
